FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk with synchronous rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");

// when the antecedent holds the consequent holds on the same edge
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: hw/rtl/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// types and constants of the positional list insert/remove block
// ----------------------------------------------------------------------------
`default_nettype none

package pli_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_CHECK,
    S_MOVE,
    S_PUT,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/positional_list_insert_remove_top.sv
// ----------------------------------------------------------------------------
// positional_list_insert_remove_top
// ordered list of signed values with insert and remove at a position
// ----------------------------------------------------------------------------
// Each transaction inserts a value at a position from 0 to the length or
// removes the entry at a position below the length, and returns one result
// with status, removed value and new length. Entries live in a single
// memory with registered read; a sequencer moves one entry at a time,
// alternating check and move states, through one shared index adder and
// compare. A rejected transaction answers in the next cycle. A new
// transaction is taken once the previous result has been taken or is
// being taken. No clearing pass is needed after reset.
`default_nettype none

`include "assert_macros.svh"

module positional_list_insert_remove_top
  import pli_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       req_type,
  input  wire logic        [POS_W-1:0]    position,
  input  wire logic signed [VAL_W-1:0]    value,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic             [STATUS_W-1:0] status,
  output logic signed      [VAL_W-1:0]    removed_value,
  output logic             [LEN_W-1:0]    length
);

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  state_t state, state_next;

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  logic [CMP_W-1:0]  pos_r;
  logic [VAL_W-1:0]  val_r;
  logic [VAL_W-1:0]  taken;
  req_t              op;

  status_t           status_r;
  logic [VAL_W-1:0]  removed_r;
  logic [LEN_W-1:0]  length_r;

  logic              in_fire;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  count_ext;
  logic              reject;
  status_t           reject_code;
  logic [CNT_W-1:0]  step;
  logic              more;

  logic              mem_we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [VAL_W-1:0]  wdata;

  assign in_fire   = in_valid && !in_stall;
  assign pos_ext   = CMP_W'(position);
  assign count_ext = CMP_W'(count);

  // request check on acceptance
  always_comb begin
    reject      = 1'b0;
    reject_code = ST_OK;
    if (req_t'(req_type) == REQ_INSERT) begin
      if (pos_ext > count_ext) begin
        reject      = 1'b1;
        reject_code = ST_RANGE;
      end else if (count == CNT_W'(CAPACITY)) begin
        reject      = 1'b1;
        reject_code = ST_FULL;
      end
    end else if (pos_ext >= count_ext) begin
      reject      = 1'b1;
      reject_code = ST_RANGE;
    end
  end

  // shared index unit
  always_comb begin
    if (op == REQ_REMOVE) begin
      step = idx + CNT_W'(1);
      more = step < count;
    end else begin
      step = idx - CNT_W'(1);
      more = CMP_W'(idx) > pos_r;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire && !reject) begin
          state_next = (req_t'(req_type) == REQ_REMOVE) ? S_TAKE : S_CHECK;
        end
      end
      S_TAKE:   state_next = S_CHECK;
      S_CHECK: begin
        if (more) begin
          state_next = S_MOVE;
        end else begin
          state_next = (op == REQ_REMOVE) ? S_FINISH : S_PUT;
        end
      end
      S_MOVE:   state_next = S_CHECK;
      S_PUT:    state_next = S_FINISH;
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = (state != S_IDLE) || (out_valid && out_stall);
    mem_we   = (state == S_MOVE) || (state == S_PUT);
    raddr    = (state == S_IDLE) ? pos_ext[ADDR_W-1:0] : step[ADDR_W-1:0];
    waddr    = (state == S_PUT) ? pos_r[ADDR_W-1:0] : idx[ADDR_W-1:0];
    wdata    = (state == S_PUT) ? val_r : rdata;
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (((state == S_IDLE) && in_fire && reject) || (state == S_FINISH)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == S_PUT) begin
        count <= count + CNT_W'(1);
      end
      if ((state == S_CHECK) && !more && (op == REQ_REMOVE)) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && in_fire) begin
      op    <= req_t'(req_type);
      pos_r <= pos_ext;
      val_r <= value;
      idx   <= (req_t'(req_type) == REQ_REMOVE) ? pos_ext[CNT_W-1:0] : count;
      taken <= '0;
      if (reject) begin
        status_r  <= reject_code;
        removed_r <= '0;
        length_r  <= LEN_W'(count);
      end
    end
    if (state == S_TAKE) begin
      taken <= rdata;
    end
    if (state == S_MOVE) begin
      idx <= step;
    end
    if (state == S_FINISH) begin
      status_r  <= ST_OK;
      removed_r <= taken;
      length_r  <= LEN_W'(count);
    end
  end

  assign status        = status_r;
  assign removed_value = removed_r;
  assign length        = length_r;

  // checks
  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(CAPACITY))
  `ASSERT_IMPLIES(a_no_write_idle, clk, rst, state == S_IDLE, !mem_we)
  `ASSERT_IMPLIES(a_result_source, clk, rst, $rose(out_valid),
    $past(state == S_FINISH) || $past(in_fire && reject))
  `ASSERT_IMPLIES(a_idx_bound, clk, rst, state == S_CHECK, idx <= count)

endmodule

`default_nettype wire

FILE: tb/sv/positional_list_insert_remove_top_test.sv
// ----------------------------------------------------------------------------
// positional_list_insert_remove_top_test
// self-checking testbench for the positional list insert/remove block
// ----------------------------------------------------------------------------
// Requests are driven on the falling edge by one send task. Each accepted
// request is run through a local list model, and its expected result is
// queued. One checker process compares every accepted result, field by field,
// with the oldest queued expectation. Directed tests cover the empty list and
// head, middle and tail positions. Further tests fill the list to capacity and
// drain it, then run random phases with insert, remove or no bias. The
// sender idles between random bursts; the receiver stalls in changing modes.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_insert_remove_top_test
  import pli_pkg::*;
();

  localparam int CAPACITY  = CAPACITY_DEF;
  localparam int MIX_ITEMS = 1250;

  typedef struct {
    status_t                  st;
    logic signed [VAL_W-1:0]  taken;
    logic        [LEN_W-1:0]  len;
  } list_result_t;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic                       req_type;
  logic        [POS_W-1:0]    position;
  logic signed [VAL_W-1:0]    value;
  logic                       out_valid;
  logic                       out_stall;
  logic        [STATUS_W-1:0] status;
  logic signed [VAL_W-1:0]    removed_value;
  logic        [LEN_W-1:0]    length;

  logic signed [VAL_W-1:0] list_model [CAPACITY];
  int                      list_len;
  list_result_t            expected_results [$];
  int                      failures;
  int                      burst_left;

  positional_list_insert_remove_top #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .position     (position),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .removed_value(removed_value),
    .length       (length)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic list_result_t predict_request(req_t req, logic [POS_W-1:0] pos,
                                                   logic signed [VAL_W-1:0] val);
    list_result_t res;
    int p;
    res.st    = ST_OK;
    res.taken = '0;
    p         = pos;
    if (req == REQ_INSERT) begin
      if (p > list_len) begin
        res.st = ST_RANGE;
      end else if (list_len >= CAPACITY) begin
        res.st = ST_FULL;
      end else begin
        for (int i = list_len; i > p; i--) list_model[i] = list_model[i-1];
        list_model[p] = val;
        list_len++;
      end
    end else begin
      if (p >= list_len) begin
        res.st = ST_RANGE;
      end else begin
        res.taken = list_model[p];
        for (int i = p; i + 1 < list_len; i++) list_model[i] = list_model[i+1];
        list_len--;
      end
    end
    res.len = LEN_W'(list_len);
    return res;
  endfunction

  task automatic send_request(req_t req, logic [POS_W-1:0] pos, logic signed [VAL_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    req_type = req;
    position = pos;
    value    = val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_request(req, pos, val));
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position(req_t req);
    case ($urandom_range(0, 9))
      0: return POS_W'($urandom_range(0, (1 << POS_W) - 1));
      1: return POS_W'(list_len);
      2: return POS_W'(list_len + 1);
      3: return ($urandom_range(0, 1) == 0) ? '0 : '1;
      default: begin
        if (req == REQ_INSERT) return POS_W'($urandom_range(0, list_len));
        if (list_len == 0) return '0;
        return POS_W'($urandom_range(0, list_len - 1));
      end
    endcase
  endfunction

  task automatic test_empty_list();
    send_request(REQ_REMOVE, 0, 32'sh5555_5555);
    send_request(REQ_REMOVE, '1, 32'shaaaa_aaaa);
    send_request(REQ_INSERT, 1, 32'sh1234_5678);
    send_request(REQ_INSERT, '1, -1);
  endtask

  task automatic test_insert_positions();
    send_request(REQ_INSERT, 0, 32'sh8000_0000);
    send_request(REQ_INSERT, 1, 32'sh7fff_ffff);
    send_request(REQ_INSERT, 1, 0);
    send_request(REQ_INSERT, 0, -1);
    send_request(REQ_INSERT, 5, 32'sh0f0f_0f0f);
    send_request(REQ_INSERT, 4, 32'sh5555_5555);
  endtask

  task automatic test_remove_positions();
    send_request(REQ_REMOVE, 5, 0);
    send_request(REQ_REMOVE, '1, 0);
    send_request(REQ_REMOVE, 2, -1);
    send_request(REQ_REMOVE, 3, 0);
    send_request(REQ_REMOVE, 0, 0);
    send_request(REQ_REMOVE, 0, 0);
    send_request(REQ_REMOVE, 0, 0);
    send_request(REQ_REMOVE, 0, 0);
  endtask

  task automatic test_fill_to_capacity();
    while (list_len < CAPACITY)
      send_request(REQ_INSERT, POS_W'($urandom_range(0, list_len)), pick_value());
    // full list: range check wins over full check beyond the length
    send_request(REQ_INSERT, 0, pick_value());
    send_request(REQ_INSERT, POS_W'(list_len), pick_value());
    send_request(REQ_INSERT, POS_W'(list_len + 1), pick_value());
    send_request(REQ_INSERT, '1, pick_value());
    send_request(REQ_REMOVE, POS_W'(list_len), pick_value());
    send_request(REQ_REMOVE, POS_W'(list_len - 1), pick_value());
    send_request(REQ_INSERT, POS_W'(list_len), pick_value());
    while (list_len > 0)
      send_request(REQ_REMOVE, POS_W'($urandom_range(0, list_len - 1)), pick_value());
  endtask

  task automatic test_random_mix();
    int sent;
    int span;
    int insert_pct;
    req_t req;
    sent = 0;
    while (sent < MIX_ITEMS) begin
      span = $urandom_range(60, 200);
      case ($urandom_range(0, 4))
        0: insert_pct = 85;
        1: insert_pct = 15;
        2: insert_pct = 70;
        3: insert_pct = 30;
        default: insert_pct = 50;
      endcase
      repeat (span) begin
        req = ($urandom_range(1, 100) <= insert_pct) ? REQ_INSERT : REQ_REMOVE;
        send_request(req, pick_position(req), pick_value());
        sent++;
      end
    end
  endtask

  // receiver stall pattern
  initial begin
    int mode;
    int span;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 3) == 0);
          2: out_stall = ($urandom_range(0, 1) == 0);
          default: out_stall = ~out_stall;
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    list_result_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transaction: status %0d removed %0d length %0d",
                 $time, status, removed_value, length);
        failures++;
      end else begin
        exp_res = expected_results.pop_front();
        if (status !== exp_res.st) begin
          $display("%0t: status expected %0d, actual %0d", $time, exp_res.st, status);
          failures++;
        end
        if (removed_value !== exp_res.taken) begin
          $display("%0t: removed_value expected %0d, actual %0d",
                   $time, exp_res.taken, removed_value);
          failures++;
        end
        if (length !== exp_res.len) begin
          $display("%0t: length expected %0d, actual %0d", $time, exp_res.len, length);
          failures++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("positional_list_insert_remove_top: mismatch");
    $finish;
  end

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    req_type   = REQ_INSERT;
    position   = '0;
    value      = '0;
    list_len   = 0;
    failures   = 0;
    burst_left = 0;
    for (int i = 0; i < CAPACITY; i++) list_model[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_list();
    test_insert_positions();
    test_remove_positions();
    test_fill_to_capacity();
    test_random_mix();

    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("positional_list_insert_remove_top: match");
    end else begin
      $display("positional_list_insert_remove_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
+incdir+hw/rtl
hw/rtl/pli_pkg.sv
hw/rtl/positional_list_insert_remove_top.sv
tb/sv/positional_list_insert_remove_top_test.sv
